### rtl/cfdf_pkg.sv
// Shared types and constants for the command frame deframer.
package cfdf_pkg;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ABORT   = 2'd2
	} kind_t;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  id;
		logic [7:0]  pbyte;
		logic [23:0] idx;
		logic [23:0] total;
		logic        done;
	} parse_res_t;

endpackage

### rtl/command_frame_deframer.sv
// Top level of the command frame deframer: input stage, parser, result register, config.
// Each accepted word (a received byte or a timer tick) is captured in an input register,
// run through the parser, and any result lands in the output register, so one word is
// accepted every clock. The single parse-state update per cycle sets that rate; the
// input stage can take a word while a result waits in the output register, and it
// stalls only when both registers hold a word and out_stall is high.
// The timeout limit register resets to 1000 and is always ready; write it only while idle.
module command_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  command_id,
	output logic [7:0]  payload_byte,
	output logic [23:0] payload_index,
	output logic [23:0] total_length,
	output logic        command_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic                 valid_s1;
	logic                 req_type_s1;
	logic [7:0]           rx_byte_s1;
	logic                 valid_s2;
	cfdf_pkg::parse_res_t res_s2;
	cfdf_pkg::parse_res_t res;
	logic [15:0]          limit_q;
	logic                 advance;
	logic                 accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= cfdf_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	cfdf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.req_type (req_type_s1),
		.rx_byte  (rx_byte_s1),
		.limit    (limit_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign result_kind   = res_s2.kind;
	assign command_id    = res_s2.id;
	assign payload_byte  = res_s2.pbyte;
	assign payload_index = res_s2.idx;
	assign total_length  = res_s2.total;
	assign command_done  = res_s2.done;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("An accepted word did not reach the input stage.");

	a_held_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(rx_byte_s1) && $stable(req_type_s1))
		else $error("A waiting word in the input stage was lost or changed.");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("Input stalled while the pipeline had room.");

endmodule

### rtl/cfdf_parser.sv
// Frame parser state and the per-word next-state and result logic.
module cfdf_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          limit,
	output cfdf_pkg::parse_res_t res
);

	typedef enum logic [2:0] {
		PH_ID   = 3'd0,
		PH_LEN1 = 3'd1,
		PH_LEN2 = 3'd2,
		PH_LEN3 = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  id_q, id_n;
	logic [23:0] len_q, len_n;
	logic [23:0] done_q, done_n;
	logic [15:0] idle_q, idle_n;
	logic [23:0] remaining;
	logic        timed_out;

	assign remaining = len_q - done_q;
	assign timed_out = (idle_q >= limit) && (phase_q != PH_ID);

	always_comb begin
		phase_n = phase_q;
		id_n    = id_q;
		len_n   = len_q;
		done_n  = done_q;
		idle_n  = idle_q;
		res     = '0;
		res.kind = cfdf_pkg::KIND_PAYLOAD;
		if (req_type == cfdf_pkg::REQ_TICK) begin
			if (idle_q < limit) begin
				idle_n = idle_q + 16'd1;
			end else begin
				idle_n = limit;
			end
		end else if (timed_out) begin
			res.valid = 1'b1;
			res.kind  = cfdf_pkg::KIND_ABORT;
			res.id    = id_q;
			res.total = len_q;
			idle_n    = '0;
			id_n      = rx_byte;
			phase_n   = PH_LEN1;
		end else begin
			idle_n = '0;
			case (phase_q)
				PH_ID: begin
					id_n    = rx_byte;
					phase_n = PH_LEN1;
				end
				PH_LEN1: begin
					len_n   = {16'd0, rx_byte};
					phase_n = PH_LEN2;
				end
				PH_LEN2: begin
					len_n   = len_q | {8'd0, rx_byte, 8'd0};
					phase_n = PH_LEN3;
				end
				PH_LEN3: begin
					len_n  = len_q | {rx_byte, 16'd0};
					done_n = '0;
					if (len_n == 24'd0) begin
						phase_n   = PH_ID;
						res.valid = 1'b1;
						res.kind  = cfdf_pkg::KIND_EMPTY;
						res.id    = id_q;
						res.done  = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					res.valid = 1'b1;
					res.id    = id_q;
					res.pbyte = rx_byte;
					res.idx   = done_q;
					res.total = len_q;
					if (remaining > 24'd1) begin
						done_n = done_q + 24'd1;
					end else begin
						res.done = 1'b1;
						done_n   = len_q;
						phase_n  = PH_ID;
					end
				end
				default: begin
					id_n    = rx_byte;
					phase_n = PH_LEN1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			id_q    <= '0;
			len_q   <= '0;
			done_q  <= '0;
			idle_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			id_q    <= id_n;
			len_q   <= len_n;
			done_q  <= done_n;
			idle_q  <= idle_n;
		end
	end

	a_tick_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && req_type == cfdf_pkg::REQ_TICK |=> $stable(phase_q))
		else $error("A tick changed the parse phase.");

	a_abort_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == cfdf_pkg::KIND_ABORT |-> !res.done)
		else $error("An abort result was flagged as command done.");

	a_byte_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && req_type == cfdf_pkg::REQ_BYTE |=> idle_q == 16'd0)
		else $error("A received byte did not clear the idle timer.");

	a_data_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_LEN3 && phase_n == PH_DATA |-> len_n != 24'd0)
		else $error("Payload phase entered with a zero length.");

endmodule

### tb/cfdf_checker.sv
// Checker for the command frame deframer: predicts every result word and compares it.
`timescale 1ns / 100ps
module cfdf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  command_id,
	input  logic [7:0]  payload_byte,
	input  logic [23:0] payload_index,
	input  logic [23:0] total_length,
	input  logic        command_done,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          payload_count,
	output int          empty_count,
	output int          abort_count
);

	typedef enum logic [2:0] {
		AWAIT_ID,
		AWAIT_LEN_LO,
		AWAIT_LEN_MID,
		AWAIT_LEN_HI,
		IN_PAYLOAD
	} frame_phase_t;

	typedef struct packed {
		cfdf_pkg::kind_t kind;
		logic [7:0]      id;
		logic [7:0]      data;
		logic [23:0]     index;
		logic [23:0]     length;
		logic            last;
	} deframed_t;

	deframed_t    expected_q[$];
	frame_phase_t phase = AWAIT_ID;
	logic [15:0]  limit_copy = cfdf_pkg::TIMEOUT_RESET;
	logic [15:0]  idle_ticks = '0;
	logic [7:0]   cur_id = '0;
	logic [23:0]  decl_len = '0;
	logic [23:0]  bytes_seen = '0;
	int           fail_count = 0;
	int           waiting = 0;
	int           n_payload = 0;
	int           n_empty = 0;
	int           n_abort = 0;

	assign errors = fail_count;
	assign pending = waiting;
	assign payload_count = n_payload;
	assign empty_count = n_empty;
	assign abort_count = n_abort;

	task automatic report_failure(input string msg);
		fail_count++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [23:0] got, input logic [23:0] want);
		if (got !== want) begin
			report_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	task automatic deframe_word(input cfdf_pkg::req_t rt, input logic [7:0] b);
		deframed_t r;
		logic      produced;
		r = '0;
		produced = 1'b0;
		if (rt == cfdf_pkg::REQ_TICK) begin
			if (idle_ticks < limit_copy) begin
				idle_ticks = idle_ticks + 16'd1;
			end else begin
				idle_ticks = limit_copy;
			end
		end else if (idle_ticks >= limit_copy && phase != AWAIT_ID) begin
			r.kind = cfdf_pkg::KIND_ABORT;
			r.id = cur_id;
			r.length = decl_len;
			produced = 1'b1;
			idle_ticks = '0;
			cur_id = b;
			phase = AWAIT_LEN_LO;
		end else begin
			idle_ticks = '0;
			case (phase)
				AWAIT_ID: begin
					cur_id = b;
					phase = AWAIT_LEN_LO;
				end
				AWAIT_LEN_LO: begin
					decl_len = {16'd0, b};
					phase = AWAIT_LEN_MID;
				end
				AWAIT_LEN_MID: begin
					decl_len[15:8] = b;
					phase = AWAIT_LEN_HI;
				end
				AWAIT_LEN_HI: begin
					decl_len[23:16] = b;
					bytes_seen = '0;
					if (decl_len == 24'd0) begin
						r.kind = cfdf_pkg::KIND_EMPTY;
						r.id = cur_id;
						r.last = 1'b1;
						produced = 1'b1;
						phase = AWAIT_ID;
					end else begin
						phase = IN_PAYLOAD;
					end
				end
				default: begin
					r.kind = cfdf_pkg::KIND_PAYLOAD;
					r.id = cur_id;
					r.data = b;
					r.index = bytes_seen;
					r.length = decl_len;
					produced = 1'b1;
					if (decl_len - bytes_seen > 24'd1) begin
						bytes_seen = bytes_seen + 24'd1;
					end else begin
						r.last = 1'b1;
						bytes_seen = decl_len;
						phase = AWAIT_ID;
					end
				end
			endcase
		end
		if (produced) begin
			expected_q.push_back(r);
		end
	endtask

	task automatic check_result();
		deframed_t want;
		if (expected_q.size() == 0) begin
			report_failure($sformatf("result kind %0d id 0x%0h arrived with nothing expected",
				result_kind, command_id));
		end else begin
			want = expected_q.pop_front();
			check_field("result_kind", 24'(result_kind), 24'(want.kind));
			check_field("command_id", 24'(command_id), 24'(want.id));
			check_field("payload_byte", 24'(payload_byte), 24'(want.data));
			check_field("payload_index", payload_index, want.index);
			check_field("total_length", total_length, want.length);
			check_field("command_done", 24'(command_done), 24'(want.last));
		end
		case (result_kind)
			cfdf_pkg::KIND_PAYLOAD: n_payload++;
			cfdf_pkg::KIND_EMPTY: n_empty++;
			default: n_abort++;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			phase = AWAIT_ID;
			limit_copy = cfdf_pkg::TIMEOUT_RESET;
			idle_ticks = '0;
			cur_id = '0;
			decl_len = '0;
			bytes_seen = '0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				limit_copy = cfg_data;
			end
			if (in_valid && !in_stall) begin
				deframe_word(cfdf_pkg::req_t'(req_type), rx_byte);
			end
		end
		waiting = expected_q.size();
	end

endmodule

### tb/tb_command_frame_deframer.sv
// Testbench top for the command frame deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_command_frame_deframer;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_SHOWN_PAYLOAD = 8;
	localparam int RANDOM_WORDS = 275;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  command_id;
	logic [7:0]  payload_byte;
	logic [23:0] payload_index;
	logic [23:0] total_length;
	logic        command_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          payload_count;
	int          empty_count;
	int          abort_count;
	int          cycle_count = 0;
	int          words_sent = 0;
	int          settings_used = 0;
	int          send_gap_pct = 7;
	int          stall_pct = 60;
	int          limit_now = cfdf_pkg::TIMEOUT_RESET;
	logic        hold_request = 1'b0;
	logic        hold_active = 1'b0;

	always #2 clk = ~clk;

	command_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.command_id   (command_id),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.total_length (total_length),
		.command_done (command_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	cfdf_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.command_id   (command_id),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.total_length (total_length),
		.command_done (command_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.payload_count(payload_count),
		.empty_count  (empty_count),
		.abort_count  (abort_count)
	);

	always @(negedge clk) begin
		out_stall <= hold_active || ($urandom_range(99) < stall_pct);
	end

	initial begin
		wait (hold_request);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_word(input cfdf_pkg::req_t rt, input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(cfdf_pkg::REQ_BYTE, b);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(cfdf_pkg::REQ_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_header(input logic [7:0] id, input logic [23:0] len);
		send_byte(id);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(len[23:16]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		limit_now = value;
		settings_used++;
	endtask

	// Usually stays under the timeout, now and then runs it out in mid-frame.
	task automatic scatter_ticks();
		if ($urandom_range(9) == 0) begin
			send_ticks($urandom_range(limit_now + 1));
		end
	endtask

	task automatic random_traffic(input int n_words);
		int          first;
		int          pick;
		int          shown;
		logic [23:0] len;
		first = words_sent;
		while (words_sent - first < n_words) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = (pick < 8) ? 24'($urandom) : 24'($urandom_range(6));
				send_byte(8'($urandom_range(255)));
				for (int i = 0; i < 3; i++) begin
					scatter_ticks();
					send_byte(len[8*i +: 8]);
				end
				shown = (len > MAX_SHOWN_PAYLOAD) ? MAX_SHOWN_PAYLOAD : int'(len);
				for (int i = 0; i < shown; i++) begin
					scatter_ticks();
					send_byte(8'($urandom_range(255)));
				end
				if (len > MAX_SHOWN_PAYLOAD) begin
					send_ticks(limit_now + 1 + $urandom_range(2));
				end
			end else if (pick < 92) begin
				send_word(cfdf_pkg::req_t'($urandom_range(1)), 8'($urandom_range(255)));
			end else begin
				send_ticks($urandom_range(limit_now + 2));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_header(8'hFF, 24'd0);
		send_header(8'h00, 24'd2);
		send_byte(8'hFF);
		send_byte(8'h00);

		write_limit(16'd3);
		send_ticks(6);
		send_byte(8'h3C);
		send_byte(8'h01);
		send_ticks(2);
		send_byte(8'h00);
		send_ticks(3);
		send_byte(8'h7E);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hAA);

		write_limit(16'd0);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		send_ticks(1);
		send_byte(8'h9A);

		write_limit(16'hFFFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_ticks(5);
		send_byte(8'hC3);

		write_limit(16'd4);
		send_ticks(7);
		send_byte(8'hC3);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h11);
		send_byte(8'hEE);
		send_byte(8'h44);
		send_byte(8'h05);
		send_ticks(5);

		// The new limit sits below the timer the block already holds.
		write_limit(16'd2);
		send_ticks(1);
		send_byte(8'h66);
		send_header(8'h00, 24'd0);

		write_limit(16'd16);
		random_traffic(RANDOM_WORDS);

		send_gap_pct = 60;
		stall_pct = 7;
		write_limit(16'd1);
		random_traffic(RANDOM_WORDS);

		send_gap_pct = 0;
		stall_pct = 0;
		write_limit(16'd5);
		hold_request = 1'b1;
		random_traffic(RANDOM_WORDS);

		wait_idle();
		$display("Run covered %0d words over %0d timeout settings, 0 to 65535.",
			words_sent, settings_used);
		$display("Results seen: %0d payload bytes, %0d empty commands, %0d timeout aborts.",
			payload_count, empty_count, abort_count);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
